[hw/rtl/hrs_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hrs_pkg: shared types, constants and float helpers
// single-precision unpack, rounding and compare used by the halley step block
// ----------------------------------------------------------------------------
package hrs_pkg;

    localparam int unsigned CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOL = 8'd1;

    localparam logic [15:0] MAX_ITER_RST = 16'd100;
    localparam logic [31:0] TOL_RST = 32'h3400_0000;
    localparam logic [31:0] QNAN = 32'h7FC0_0000;
    localparam logic [31:0] FP_TWO = 32'h4000_0000;
    localparam logic [16:0] COUNT_MAX = 17'h1FFFF;
    localparam logic [4:0] DIV_LAST = 5'd26;

    typedef enum logic [1:0] {FOP_MUL, FOP_SUB, FOP_DIV} fpu_op_t;
    typedef enum logic [2:0] {A_SLOPE, A_VAL, A_TMP, A_T2, A_X} asel_t;
    typedef enum logic [2:0] {B_TWO, B_SLOPE, B_CURV, B_TMP, B_DEN, B_DX} bsel_t;
    typedef enum logic [2:0] {D_TMP, D_T2, D_DEN, D_DX, D_XN} dst_t;
    typedef enum logic [1:0] {K_START, K_IDLE, K_FAIL, K_UPD} kind_t;

    typedef struct packed {
        logic    load_in;
        logic    fpu_start;
        fpu_op_t fpu_op;
        asel_t   a_sel;
        bsel_t   b_sel;
        dst_t    dst;
        logic    out_load;
        kind_t   kind;
    } dp_cmd_t;

    typedef struct packed {
        logic opcode;
        logic searching;
        logic fpu_done;
        logic den_zero;
        logic out_free;
    } dp_stat_t;

    typedef struct packed {
        logic               sign;
        logic               nan;
        logic               inf;
        logic               zero;
        logic signed [11:0] exp;
        logic [23:0]        sig;
    } unp_t;

    typedef struct packed {
        logic               sign;
        logic               nan;
        logic               inf;
        logic               zero;
        logic signed [11:0] exp;
        logic [26:0]        sig;
    } norm_t;

    function automatic logic [4:0] lzc27(input logic [26:0] v);
        logic [4:0] n;
        n = 5'd27;
        for (int i = 0; i < 27; i++)
        begin
            if (v[i])
            begin
                n = 5'(26 - i);
            end
        end
        return n;
    endfunction

    function automatic logic [26:0] shr_sticky(input logic [26:0] v, input logic [11:0] amt);
        logic [26:0] r;
        logic [26:0] m;
        m = '0;
        if (amt >= 12'd27)
        begin
            r = {26'b0, |v};
        end
        else
        begin
            r = v >> amt[4:0];
            m = ~({27{1'b1}} << amt[4:0]);
            r[0] = r[0] | (|(v & m));
        end
        return r;
    endfunction

    function automatic unp_t unpack(input logic [31:0] f);
        unp_t       u;
        logic [4:0] lz;
        u.sign = f[31];
        u.nan = (f[30:23] == 8'hFF) && (f[22:0] != 23'b0);
        u.inf = (f[30:23] == 8'hFF) && (f[22:0] == 23'b0);
        u.zero = (f[30:23] == 8'h00) && (f[22:0] == 23'b0);
        lz = lzc27({1'b0, f[22:0], 3'b0});
        if (f[30:23] == 8'h00)
        begin
            u.sig = 24'({1'b0, f[22:0]} << lz);
            u.exp = 12'sd1 - $signed({7'b0, lz});
        end
        else
        begin
            u.sig = {1'b1, f[22:0]};
            u.exp = $signed({4'b0, f[30:23]});
        end
        return u;
    endfunction

    function automatic logic [31:0] round_pack(input norm_t n);
        logic [26:0] sg;
        logic [7:0]  ef;
        logic [30:0] base;
        logic        inc;
        logic [31:0] r;
        logic [11:0] sh;
        sg = n.sig;
        ef = 8'h00;
        sh = 12'(12'sd1 - n.exp);
        if (n.nan)
        begin
            r = QNAN;
        end
        else if (n.inf || (n.exp >= 12'sd255))
        begin
            r = {n.sign, 8'hFF, 23'b0};
        end
        else if (n.zero)
        begin
            r = {n.sign, 31'b0};
        end
        else
        begin
            if (n.exp <= 12'sd0)
            begin
                sg = shr_sticky(n.sig, sh);
                ef = 8'h00;
            end
            else
            begin
                sg = n.sig;
                ef = n.exp[7:0];
            end
            inc = sg[2] & (sg[3] | sg[1] | sg[0]);
            base = {ef, sg[25:3]};
            r = {n.sign, base + {30'b0, inc}};
        end
        return r;
    endfunction

    function automatic logic is_nan(input logic [31:0] f);
        return (f[30:23] == 8'hFF) && (f[22:0] != 23'b0);
    endfunction

    // magnitude a (sign clear) greater than signed float e
    function automatic logic mag_gt(input logic [31:0] a, input logic [31:0] e);
        logic r;
        if (is_nan(a) || is_nan(e))
        begin
            r = 1'b0;
        end
        else if (e[31])
        begin
            r = !((a[30:0] == 31'b0) && (e[30:0] == 31'b0));
        end
        else
        begin
            r = a[30:0] > e[30:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

[hw/rtl/hrs_fpu.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hrs_fpu: shared single-precision unit
// multiply, subtract and radix-2 divide with round to nearest even
// ----------------------------------------------------------------------------
module hrs_fpu
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire hrs_pkg::fpu_op_t op,
    input  wire logic [31:0]      a,
    input  wire logic [31:0]      b,
    output logic                  done,
    output logic [31:0]           result
);
    import hrs_pkg::*;

    typedef enum logic [2:0] {F_IDLE, F_PREP, F_MUL, F_NORM, F_DIV, F_RND} fstate_t;

    fstate_t     state_reg, state_next;
    logic        done_reg, done_next;
    fpu_op_t     op_reg, op_next;
    unp_t        ua_reg, ua_next, ub_reg, ub_next;
    logic [47:0] prod_reg, prod_next;
    logic [27:0] sum_reg, sum_next;
    logic [24:0] rem_reg, rem_next;
    logic [23:0] dvs_reg, dvs_next;
    logic [25:0] quo_reg, quo_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        zsign_reg, zsign_next;
    norm_t       norm_reg, norm_next;
    logic [31:0] result_reg, result_next;

    unp_t        ul, us;
    logic        swap, lt, ge;
    logic [11:0] dsh;
    logic [26:0] sl, ss;
    logic [24:0] diff;
    logic [4:0]  lz;

    always_comb
    begin
        state_next = state_reg;
        done_next = 1'b0;
        op_next = op_reg;
        ua_next = ua_reg;
        ub_next = ub_reg;
        prod_next = prod_reg;
        sum_next = sum_reg;
        rem_next = rem_reg;
        dvs_next = dvs_reg;
        quo_next = quo_reg;
        cnt_next = cnt_reg;
        zsign_next = zsign_reg;
        norm_next = norm_reg;
        result_next = result_reg;
        swap = (ub_reg.exp > ua_reg.exp)
            || ((ub_reg.exp == ua_reg.exp) && (ub_reg.sig > ua_reg.sig));
        ul = swap ? ub_reg : ua_reg;
        us = swap ? ua_reg : ub_reg;
        dsh = 12'(ul.exp - us.exp);
        sl = {ul.sig, 3'b0};
        ss = shr_sticky({us.sig, 3'b0}, dsh);
        lt = ua_reg.sig < ub_reg.sig;
        ge = rem_reg >= {1'b0, dvs_reg};
        diff = ge ? (rem_reg - {1'b0, dvs_reg}) : rem_reg;
        lz = lzc27(sum_reg[26:0]);

        case (state_reg)
            F_IDLE:
            begin
                if (start)
                begin
                    op_next = op;
                    ua_next = unpack(a);
                    ub_next = unpack(b);
                    if (op == FOP_SUB)
                    begin
                        ub_next.sign = ~b[31];
                    end
                    state_next = F_PREP;
                end
            end
            F_PREP:
            begin
                norm_next.sign = ua_reg.sign ^ ub_reg.sign;
                norm_next.sig = '0;
                case (op_reg)
                    FOP_MUL:
                    begin
                        prod_next = 48'(ua_reg.sig * ub_reg.sig);
                        norm_next.nan = ua_reg.nan || ub_reg.nan
                            || (ua_reg.inf && ub_reg.zero) || (ua_reg.zero && ub_reg.inf);
                        norm_next.inf = ua_reg.inf || ub_reg.inf;
                        norm_next.zero = ua_reg.zero || ub_reg.zero;
                        norm_next.exp = ua_reg.exp + ub_reg.exp - 12'sd127;
                        state_next = F_MUL;
                    end
                    FOP_SUB:
                    begin
                        if (ul.sign != us.sign)
                        begin
                            sum_next = {1'b0, sl} - {1'b0, ss};
                        end
                        else
                        begin
                            sum_next = {1'b0, sl} + {1'b0, ss};
                        end
                        norm_next.nan = ua_reg.nan || ub_reg.nan
                            || (ua_reg.inf && ub_reg.inf && (ua_reg.sign != ub_reg.sign));
                        norm_next.inf = ua_reg.inf || ub_reg.inf;
                        norm_next.zero = 1'b0;
                        norm_next.sign = ua_reg.inf ? ua_reg.sign
                            : (ub_reg.inf ? ub_reg.sign : ul.sign);
                        norm_next.exp = ul.exp;
                        zsign_next = ua_reg.zero && ub_reg.zero && ua_reg.sign && ub_reg.sign;
                        state_next = F_NORM;
                    end
                    FOP_DIV:
                    begin
                        dvs_next = ub_reg.sig;
                        rem_next = lt ? {ua_reg.sig, 1'b0} : {1'b0, ua_reg.sig};
                        quo_next = '0;
                        cnt_next = '0;
                        norm_next.nan = ua_reg.nan || ub_reg.nan
                            || (ua_reg.inf && ub_reg.inf) || (ua_reg.zero && ub_reg.zero);
                        norm_next.inf = ua_reg.inf || ub_reg.zero;
                        norm_next.zero = ua_reg.zero || ub_reg.inf;
                        norm_next.exp = ua_reg.exp - ub_reg.exp + 12'sd127
                            - (lt ? 12'sd1 : 12'sd0);
                        state_next = F_DIV;
                    end
                    default:
                    begin
                        state_next = F_IDLE;
                    end
                endcase
            end
            F_MUL:
            begin
                if (prod_reg[47])
                begin
                    norm_next.sig = prod_reg[47:21] | {26'b0, |prod_reg[20:0]};
                    norm_next.exp = norm_reg.exp + 12'sd1;
                end
                else
                begin
                    norm_next.sig = prod_reg[46:20] | {26'b0, |prod_reg[19:0]};
                end
                state_next = F_RND;
            end
            F_NORM:
            begin
                if (sum_reg[27])
                begin
                    norm_next.sig = sum_reg[27:1] | {26'b0, sum_reg[0]};
                    norm_next.exp = norm_reg.exp + 12'sd1;
                end
                else
                begin
                    norm_next.sig = sum_reg[26:0] << lz;
                    norm_next.exp = norm_reg.exp - $signed({7'b0, lz});
                end
                if (sum_reg == 28'b0)
                begin
                    norm_next.zero = 1'b1;
                    norm_next.sign = zsign_reg;
                end
                state_next = F_RND;
            end
            F_DIV:
            begin
                rem_next = {diff[23:0], 1'b0};
                quo_next = {quo_reg[24:0], ge};
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == DIV_LAST)
                begin
                    norm_next.sig = {quo_reg, ge} | {26'b0, diff != 25'b0};
                    state_next = F_RND;
                end
            end
            F_RND:
            begin
                result_next = round_pack(norm_reg);
                done_next = 1'b1;
                state_next = F_IDLE;
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
        ua_reg <= ua_next;
        ub_reg <= ub_next;
        prod_reg <= prod_next;
        sum_reg <= sum_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
        cnt_reg <= cnt_next;
        zsign_reg <= zsign_next;
        norm_reg <= norm_next;
        result_reg <= result_next;
    end

    assign done = done_reg;
    assign result = result_reg;

endmodule
`default_nettype wire

[hw/rtl/hrs_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hrs_dp: datapath of the halley step block
// operand and search state registers, config registers, output register
// ----------------------------------------------------------------------------
module hrs_dp
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic [127:0]                      s_tdata,
    input  wire logic                              s_tuser,
    input  wire logic                              cfg_valid,
    input  wire logic [hrs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [31:0]                       cfg_data,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [55:0]                            m_tdata,
    output logic                                   m_tlast,
    output logic                                   m_tuser,
    input  wire hrs_pkg::dp_cmd_t                  cmd,
    output hrs_pkg::dp_stat_t                      stat
);
    import hrs_pkg::*;

    logic [15:0] max_iter_reg;
    logic [31:0] tol_reg;
    logic        op_reg;
    logic [31:0] start_reg, val_reg, slope_reg, curv_reg;
    logic [31:0] tmp_reg, t2_reg, den_reg, dx_reg, xn_reg;
    logic [31:0] x_reg, x_next;
    logic [16:0] count_reg, count_next;
    logic        searching_reg, searching_next;
    logic        mvalid_reg, mvalid_next;
    logic [31:0] pt_out_reg, pt_out_next;
    logic [16:0] it_out_reg, it_out_next;
    logic        done_out_reg, done_out_next, fail_out_reg, fail_out_next;

    logic        fpu_done;
    logic [31:0] fpu_res, fa, fb, xc;
    logic [16:0] cnt_inc;
    logic        stop;

    hrs_fpu u_fpu
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.fpu_start),
        .op     (cmd.fpu_op),
        .a      (fa),
        .b      (fb),
        .done   (fpu_done),
        .result (fpu_res)
    );

    always_comb
    begin
        case (cmd.a_sel)
            A_SLOPE: fa = slope_reg;
            A_VAL:   fa = val_reg;
            A_TMP:   fa = tmp_reg;
            A_T2:    fa = t2_reg;
            A_X:     fa = x_reg;
            default: fa = x_reg;
        endcase
        case (cmd.b_sel)
            B_TWO:   fb = FP_TWO;
            B_SLOPE: fb = slope_reg;
            B_CURV:  fb = curv_reg;
            B_TMP:   fb = tmp_reg;
            B_DEN:   fb = den_reg;
            B_DX:    fb = dx_reg;
            default: fb = dx_reg;
        endcase
    end

    always_comb
    begin
        xc = is_nan(xn_reg) ? QNAN : xn_reg;
        cnt_inc = (count_reg == COUNT_MAX) ? count_reg : (count_reg + 17'd1);
        stop = !mag_gt({1'b0, dx_reg[30:0]}, tol_reg)
            || ((cnt_inc >= 17'd2) && (cnt_inc > {1'b0, max_iter_reg}));

        x_next = x_reg;
        count_next = count_reg;
        searching_next = searching_reg;
        pt_out_next = pt_out_reg;
        it_out_next = it_out_reg;
        done_out_next = done_out_reg;
        fail_out_next = fail_out_reg;
        mvalid_next = m_tready ? 1'b0 : mvalid_reg;

        if (cmd.out_load)
        begin
            mvalid_next = 1'b1;
            case (cmd.kind)
                K_START:
                begin
                    x_next = start_reg;
                    count_next = '0;
                    searching_next = 1'b1;
                    pt_out_next = start_reg;
                    done_out_next = 1'b0;
                    fail_out_next = 1'b0;
                    it_out_next = '0;
                end
                K_IDLE:
                begin
                    pt_out_next = x_reg;
                    done_out_next = 1'b1;
                    fail_out_next = 1'b0;
                    it_out_next = count_reg;
                end
                K_FAIL:
                begin
                    x_next = QNAN;
                    searching_next = 1'b0;
                    pt_out_next = QNAN;
                    done_out_next = 1'b1;
                    fail_out_next = 1'b1;
                    it_out_next = count_reg;
                end
                K_UPD:
                begin
                    x_next = xc;
                    count_next = cnt_inc;
                    searching_next = !stop;
                    pt_out_next = xc;
                    done_out_next = stop;
                    fail_out_next = 1'b0;
                    it_out_next = cnt_inc;
                end
                default:
                begin
                    mvalid_next = mvalid_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_iter_reg <= MAX_ITER_RST;
            tol_reg <= TOL_RST;
            x_reg <= '0;
            count_reg <= '0;
            searching_reg <= 1'b0;
            mvalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && (cfg_index == CFG_MAX_ITER))
            begin
                max_iter_reg <= cfg_data[15:0];
            end
            if (cfg_valid && (cfg_index == CFG_TOL))
            begin
                tol_reg <= cfg_data;
            end
            x_reg <= x_next;
            count_reg <= count_next;
            searching_reg <= searching_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg <= s_tuser;
            start_reg <= s_tdata[31:0];
            val_reg <= s_tdata[63:32];
            slope_reg <= s_tdata[95:64];
            curv_reg <= s_tdata[127:96];
        end
        if (fpu_done)
        begin
            case (cmd.dst)
                D_TMP:   tmp_reg <= fpu_res;
                D_T2:    t2_reg <= fpu_res;
                D_DEN:   den_reg <= fpu_res;
                D_DX:    dx_reg <= fpu_res;
                D_XN:    xn_reg <= fpu_res;
                default: xn_reg <= fpu_res;
            endcase
        end
        pt_out_reg <= pt_out_next;
        it_out_reg <= it_out_next;
        done_out_reg <= done_out_next;
        fail_out_reg <= fail_out_next;
    end

    assign stat.opcode = op_reg;
    assign stat.searching = searching_reg;
    assign stat.fpu_done = fpu_done;
    assign stat.den_zero = fpu_res[30:0] == 31'b0;
    assign stat.out_free = !mvalid_reg || m_tready;

    assign m_tvalid = mvalid_reg;
    assign m_tdata = {7'b0, it_out_reg, pt_out_reg};
    assign m_tlast = done_out_reg;
    assign m_tuser = fail_out_reg;

endmodule
`default_nettype wire

[hw/rtl/hrs_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hrs_ctrl: sequencer of the halley step block
// walks the multiply, subtract and divide steps of one update
// ----------------------------------------------------------------------------
module hrs_ctrl
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire hrs_pkg::dp_stat_t stat,
    output hrs_pkg::dp_cmd_t       cmd
);
    import hrs_pkg::*;

    typedef enum logic [2:0] {C_IDLE, C_DECIDE, C_ISSUE, C_WAIT, C_OUT} cstate_t;
    typedef enum logic [2:0] {ST_T1, ST_T2, ST_T3, ST_DEN, ST_N1, ST_NUM, ST_DIV, ST_X} step_t;

    cstate_t state_reg, state_next;
    step_t   step_reg, step_next;
    kind_t   kind_reg, kind_next;

    always_comb
    begin
        cmd.load_in = (state_reg == C_IDLE) && s_tvalid;
        cmd.fpu_start = state_reg == C_ISSUE;
        cmd.out_load = (state_reg == C_OUT) && stat.out_free;
        cmd.kind = kind_reg;
        case (step_reg)
            ST_T1:
            begin
                cmd.fpu_op = FOP_MUL; cmd.a_sel = A_SLOPE; cmd.b_sel = B_TWO; cmd.dst = D_TMP;
            end
            ST_T2:
            begin
                cmd.fpu_op = FOP_MUL; cmd.a_sel = A_TMP; cmd.b_sel = B_SLOPE; cmd.dst = D_T2;
            end
            ST_T3:
            begin
                cmd.fpu_op = FOP_MUL; cmd.a_sel = A_VAL; cmd.b_sel = B_CURV; cmd.dst = D_TMP;
            end
            ST_DEN:
            begin
                cmd.fpu_op = FOP_SUB; cmd.a_sel = A_T2; cmd.b_sel = B_TMP; cmd.dst = D_DEN;
            end
            ST_N1:
            begin
                cmd.fpu_op = FOP_MUL; cmd.a_sel = A_VAL; cmd.b_sel = B_TWO; cmd.dst = D_TMP;
            end
            ST_NUM:
            begin
                cmd.fpu_op = FOP_MUL; cmd.a_sel = A_TMP; cmd.b_sel = B_SLOPE; cmd.dst = D_TMP;
            end
            ST_DIV:
            begin
                cmd.fpu_op = FOP_DIV; cmd.a_sel = A_TMP; cmd.b_sel = B_DEN; cmd.dst = D_DX;
            end
            ST_X:
            begin
                cmd.fpu_op = FOP_SUB; cmd.a_sel = A_X; cmd.b_sel = B_DX; cmd.dst = D_XN;
            end
            default:
            begin
                cmd.fpu_op = FOP_SUB; cmd.a_sel = A_X; cmd.b_sel = B_DX; cmd.dst = D_XN;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        step_next = step_reg;
        kind_next = kind_reg;
        case (state_reg)
            C_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = C_DECIDE;
                end
            end
            C_DECIDE:
            begin
                if (!stat.opcode)
                begin
                    kind_next = K_START;
                    state_next = C_OUT;
                end
                else if (!stat.searching)
                begin
                    kind_next = K_IDLE;
                    state_next = C_OUT;
                end
                else
                begin
                    step_next = ST_T1;
                    state_next = C_ISSUE;
                end
            end
            C_ISSUE:
            begin
                state_next = C_WAIT;
            end
            C_WAIT:
            begin
                if (stat.fpu_done)
                begin
                    if ((step_reg == ST_DEN) && stat.den_zero)
                    begin
                        kind_next = K_FAIL;
                        state_next = C_OUT;
                    end
                    else if (step_reg == ST_X)
                    begin
                        kind_next = K_UPD;
                        state_next = C_OUT;
                    end
                    else
                    begin
                        step_next = step_t'(step_reg + 3'd1);
                        state_next = C_ISSUE;
                    end
                end
            end
            C_OUT:
            begin
                if (stat.out_free)
                begin
                    state_next = C_IDLE;
                end
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            step_reg <= ST_T1;
            kind_reg <= K_IDLE;
        end
        else
        begin
            state_reg <= state_next;
            step_reg <= step_next;
            kind_reg <= kind_next;
        end
    end

    assign s_tready = state_reg == C_IDLE;

endmodule
`default_nettype wire

[hw/rtl/halley_root_step_f32_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// halley_root_step_f32_top: single-precision halley iteration step
// start items load a guess, evaluation items apply one halley update
// ----------------------------------------------------------------------------
// start items and evaluations while idle: the result goes to the output register once it is free
// update items: one shared fpu runs five multiplies, two subtracts and a radix-2 divide
// in turn; one item at a time
// the next item is taken while a result waits in the output register
// reset (async, active low): idle, point and count zero, config at defaults
module halley_root_step_f32_top
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [127:0]                  s_tdata,  // start_point, value, slope, curvature
    input  wire logic                          s_tuser,  // opcode
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [55:0]                        m_tdata,  // point, iterations, zero fill
    output logic                               m_tlast,
    output logic                               m_tuser,  // failed
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [hrs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]                   cfg_data
);
    import hrs_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    hrs_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    hrs_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .stat      (stat)
    );

    assign cfg_ready = 1'b1;

endmodule
`default_nettype wire
